@@ hdl/ssr_pkg.sv @@
package ssr_pkg;

  // default sizing of the store
  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int GROUP_W  = 6;
  localparam int GSIZE_W  = 7;
  localparam int HELD_W   = 7;
  localparam int STATUS_W = 2;

  // group size after reset
  localparam logic [GSIZE_W-1:0] GSIZE_RESET = 7'd5;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_AT = 2'd2;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOGROUP = 2'd3
  } status_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic act;    // execute cycle, refresh the tap
    logic load;   // take the pushed word
    logic shift;  // take the upper neighbor's word
    logic tap;    // this cell holds the popped word
  } cell_ctl_t;

endpackage

@@ hdl/ssr_cell.sv @@
module ssr_cell #(
  parameter int WORD_BITS = ssr_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  ssr_pkg::cell_ctl_t    ctl,
  input  logic [WORD_BITS-1:0]  load_word,
  input  logic [WORD_BITS-1:0]  up_word,
  output logic [WORD_BITS-1:0]  word,
  output logic [WORD_BITS-1:0]  tap
);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] tap_r;

  // tap samples the old word, the word is loaded or moved down
  always_ff @(posedge clk) begin
    if (ctl.act) begin
      tap_r <= ctl.tap ? word_r : '0;
      if (ctl.load) begin
        word_r <= load_word;
      end else if (ctl.shift) begin
        word_r <= up_word;
      end
    end
  end

  assign word = word_r;
  assign tap  = tap_r;

endmodule

@@ hdl/ssr_reduce.sv @@
module ssr_reduce #(
  parameter int DEPTH     = ssr_pkg::DEPTH_DEF,
  parameter int WORD_BITS = ssr_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [WORD_BITS-1:0]  taps [DEPTH],
  output logic [WORD_BITS-1:0]  result
);

  localparam int CHUNK = 32;
  localparam int NPART = (DEPTH + CHUNK - 1) / CHUNK;

  logic [WORD_BITS-1:0] part_r   [NPART];
  logic [WORD_BITS-1:0] part_nxt [NPART];

  // first level: or of each chunk of taps
  always_comb begin
    for (int k = 0; k < NPART; k++) begin
      part_nxt[k] = '0;
      for (int j = 0; j < CHUNK; j++) begin
        if (k * CHUNK + j < DEPTH) begin
          part_nxt[k] = part_nxt[k] | taps[k * CHUNK + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_r <= part_nxt;
    end
  end

  // second level: or of the registered chunk results
  always_comb begin
    result = '0;
    for (int k = 0; k < NPART; k++) begin
      result = result | part_r[k];
    end
  end

endmodule

@@ hdl/segmented_stack_with_remove_at_top.sv @@
// channel   ports                      fields (lowest bit up)
// input     in_tvalid/in_tready        tuser: kind; tdata: value, group, zero pad
// result    out_tvalid/out_tready      tuser: status; tdata: data, held, zero pad
// config    cfg_wr_en/cfg_wr_data      group_size, no read-back
//
// one request passes these steps from accept to result in the output register:
// accept, group base product, cell update, first or-tree level, result load.
// the next request is accepted the cycle after the result is loaded, even while it waits.
// the multiplier and the registered or-tree over the cell taps each take a step of their own.
// reset clears the count and the handshakes and sets the group size to five; cells need no clearing.
// a stalled result holds the block in its last step until out_tready.
module segmented_stack_with_remove_at_top #(
  parameter int DEPTH     = ssr_pkg::DEPTH_DEF,
  parameter int WORD_BITS = ssr_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // kind
  input  logic [39:0] in_tdata,    // value [31:0], group [37:32], zero [39:38]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,   // status
  output logic [39:0] out_tdata,   // data [31:0], held [38:32], zero [39]
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data  // group_size
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ssr_pkg::GROUP_W + ssr_pkg::GSIZE_W;
  localparam int AW = (PW > CW ? PW : CW) + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_EXEC = 5'b00100,
    S_RED  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [ssr_pkg::GSIZE_W-1:0] group_size_r;
  logic [ssr_pkg::KIND_W-1:0]  kind_r;
  logic [ssr_pkg::VALUE_W-1:0] value_r;
  logic [ssr_pkg::GROUP_W-1:0] grp_r;
  logic [AW-1:0]               base_r;
  logic [CW-1:0]               count_r, count_nxt;
  ssr_pkg::status_t            status_r, status_nxt;
  logic [ssr_pkg::HELD_W-1:0]  held_r;

  logic                        out_valid_r;
  logic [ssr_pkg::VALUE_W-1:0] out_data_r;
  ssr_pkg::status_t            out_status_r;
  logic [ssr_pkg::HELD_W-1:0]  out_held_r;

  logic [ssr_pkg::GSIZE_W-1:0] gs;
  logic [AW-1:0]               cnt_ext, top_pos, grp_end, pos;
  logic                        is_push, is_pop, is_pop_at, op_ok, out_load;
  logic [WORD_BITS-1:0]        red_word;
  logic [WORD_BITS-1:0]        words [DEPTH];
  logic [WORD_BITS-1:0]        taps  [DEPTH];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= ssr_pkg::GSIZE_RESET;
    end else if (cfg_wr_en) begin
      group_size_r <= cfg_wr_data;
    end
  end

  assign gs = (group_size_r == '0) ? ssr_pkg::GSIZE_W'(1) : group_size_r;

  // request decode and position select
  assign is_push   = (kind_r == ssr_pkg::KIND_PUSH);
  assign is_pop    = (kind_r == ssr_pkg::KIND_POP);
  assign is_pop_at = (kind_r == ssr_pkg::KIND_POP_AT);
  assign cnt_ext   = AW'(count_r);
  assign top_pos   = cnt_ext - AW'(1);
  assign grp_end   = base_r + AW'(gs) - AW'(1);

  always_comb begin
    if (is_push) begin
      pos = cnt_ext;
    end else if (is_pop) begin
      pos = top_pos;
    end else begin
      pos = (grp_end > top_pos) ? top_pos : grp_end;
    end
  end

  // status and next count
  always_comb begin
    status_nxt = ssr_pkg::ST_OK;
    count_nxt  = count_r;
    if (is_push) begin
      if (count_r >= CW'(DEPTH)) begin
        status_nxt = ssr_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else if (is_pop) begin
      if (count_r == '0) begin
        status_nxt = ssr_pkg::ST_EMPTY;
      end else begin
        count_nxt = count_r - CW'(1);
      end
    end else if (is_pop_at) begin
      if (base_r >= cnt_ext) begin
        status_nxt = ssr_pkg::ST_NOGROUP;
      end else begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  assign op_ok = (status_nxt == ssr_pkg::ST_OK) && (state_r == S_EXEC);

  // row of cells, bottom at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ssr_pkg::cell_ctl_t ctl;
    logic [WORD_BITS-1:0] up;

    assign ctl.act   = (state_r == S_EXEC);
    assign ctl.load  = op_ok && is_push && (pos == AW'(i));
    assign ctl.shift = op_ok && is_pop_at && (AW'(i) >= pos);
    assign ctl.tap   = op_ok && (is_pop || is_pop_at) && (pos == AW'(i));

    if (i == DEPTH - 1) begin : g_top
      assign up = words[i];
    end else begin : g_mid
      assign up = words[i + 1];
    end

    ssr_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_word (WORD_BITS'(value_r)),
      .up_word   (up),
      .word      (words[i]),
      .tap       (taps[i])
    );
  end

  // gather the popped word from the taps
  ssr_reduce #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_reduce (
    .clk    (clk),
    .en     (state_r == S_RED),
    .taps   (taps),
    .result (red_word)
  );

  // sequencer
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_RED;
      S_RED:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC) begin
        count_r <= count_nxt;
      end
    end
  end

  // request capture, group base and per-request results
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r  <= in_tuser;
      value_r <= in_tdata[31:0];
      grp_r   <= in_tdata[37:32];
    end
    if (state_r == S_MUL) begin
      base_r <= AW'(grp_r) * AW'(gs);
    end
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
      held_r   <= ssr_pkg::HELD_W'(count_nxt);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r   <= ssr_pkg::VALUE_W'(red_word);
      out_status_r <= status_r;
      out_held_r   <= held_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_held_r, out_data_r};

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count beyond depth");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && (status_nxt != ssr_pkg::ST_OK) |=> $stable(count_r))
    else $error("failed request changed the count");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ssr_pkg::ST_EMPTY) |->
      (out_held_r == '0) && (out_data_r == '0))
    else $error("empty pop result not zero");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ssr_pkg::ST_FULL) |->
      (out_held_r == ssr_pkg::HELD_W'(DEPTH)) && (out_data_r == '0))
    else $error("dropped push result wrong");
`endif

endmodule

@@ tb/tb_segmented_stack_with_remove_at_top.sv @@
`timescale 1ns / 100ps

module tb_segmented_stack_with_remove_at_top;
  import ssr_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENT_REQUESTS = 95;
  localparam int DUE_SLOTS = 16;

  // one expected result of a stack request
  typedef struct {
    logic signed [VALUE_W-1:0] data;
    status_t status;
    logic [HELD_W-1:0] held;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [1:0] in_tuser;
  logic [39:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [1:0] out_tuser;
  logic [39:0] out_tdata;
  logic cfg_wr_en;
  logic [6:0] cfg_wr_data;

  // stack mirror and pending results
  logic signed [VALUE_W-1:0] word_store [STACK_DEPTH];
  int words_held;
  int group_size_now;
  stack_result_t due_ring [DUE_SLOTS];
  int due_wr;
  int due_rd;

  int fail_count;
  int cycle_count;
  bit tx_idle;
  bit rx_idle;
  int rx_hold_cycles;

  segmented_stack_with_remove_at_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // apply one accepted request to the stack mirror
  task automatic predict_stack_op(input logic [KIND_W-1:0] kind,
                                  input logic signed [VALUE_W-1:0] word,
                                  input logic [GROUP_W-1:0] grp);
    stack_result_t r;
    int gs;
    int base;
    int pos;
    int i;
    r.data = '0;
    r.status = ST_OK;
    case (kind)
      KIND_PUSH: begin
        if (words_held >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          word_store[words_held] = word;
          words_held++;
        end
      end
      KIND_POP: begin
        if (words_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          words_held--;
          r.data = word_store[words_held];
        end
      end
      KIND_POP_AT: begin
        gs = (group_size_now == 0) ? 1 : group_size_now;
        base = int'(grp) * gs;
        if (base >= words_held) begin
          r.status = ST_NOGROUP;
        end else begin
          pos = base + gs - 1;
          if (pos > words_held - 1) pos = words_held - 1;
          r.data = word_store[pos];
          // later words close the gap
          for (i = pos; i + 1 < words_held; i++) word_store[i] = word_store[i + 1];
          words_held--;
        end
      end
      default: ;
    endcase
    r.held = words_held[HELD_W-1:0];
    due_ring[due_wr % DUE_SLOTS] = r;
    due_wr++;
  endtask

  // offer one request and wait for its acceptance
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic signed [VALUE_W-1:0] word,
                              input logic [GROUP_W-1:0] grp);
    int gap;
    bit taken;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {2'b00, grp, word};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    predict_stack_op(kind, word, grp);
  endtask

  // stop offering and let every pending result come back
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (due_wr != due_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_group_size(input int gs);
    wait_all_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= gs[6:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    group_size_now = gs;
  endtask

  // random request, mostly aimed at groups that hold words
  task automatic send_random_request(input int push_pct);
    int pick;
    int gs;
    int top_grp;
    logic [KIND_W-1:0] kind;
    logic [GROUP_W-1:0] grp;
    pick = $urandom_range(0, 99);
    if (pick < 2) kind = KIND_NOP;
    else if (pick < push_pct) kind = KIND_PUSH;
    else if (pick < push_pct + (100 - push_pct) / 3) kind = KIND_POP;
    else kind = KIND_POP_AT;
    grp = GROUP_W'($urandom_range(0, 63));
    if (kind == KIND_POP_AT && words_held > 0 && $urandom_range(0, 9) < 8) begin
      gs = (group_size_now == 0) ? 1 : group_size_now;
      top_grp = (words_held - 1) / gs;
      if (top_grp > 63) top_grp = 63;
      grp = GROUP_W'($urandom_range(0, top_grp));
    end
    send_request(kind, $urandom, grp);
  endtask

  // result checker
  initial begin
    logic [1:0] got_status;
    logic [39:0] got_tdata;
    stack_result_t want;
    int gap;
    bit seen;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        seen = out_tvalid;
        got_status = out_tuser;
        got_tdata = out_tdata;
        @(posedge clk);
      end while (!seen);
      if (due_wr == due_rd) begin
        $error("result with no request pending: data %0d status %0d held %0d",
               $signed(got_tdata[31:0]), got_status, got_tdata[38:32]);
        fail_count++;
      end else begin
        want = due_ring[due_rd % DUE_SLOTS];
        due_rd++;
        if (got_tdata[31:0] !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, $signed(got_tdata[31:0]));
          fail_count++;
        end
        if (got_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got_status);
          fail_count++;
        end
        if (got_tdata[38:32] !== want.held) begin
          $error("held: expected %0d, got %0d", want.held, got_tdata[38:32]);
          fail_count++;
        end
      end
    end
  end

  // empty store, extreme words, every request kind, shift in the middle
  task automatic test_directed_kinds();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_request(KIND_POP, 32'sd0, 6'd0);
    send_request(KIND_POP_AT, 32'sd0, 6'd0);
    send_request(KIND_POP_AT, 32'sd0, 6'd63);
    send_request(KIND_NOP, 32'sh5A5A_A5A5, 6'h2A);
    send_request(KIND_PUSH, 32'sh8000_0000, 6'h3F);
    send_request(KIND_PUSH, 32'sh7FFF_FFFF, 6'd0);
    send_request(KIND_PUSH, 32'sd0, 6'h15);
    send_request(KIND_PUSH, -32'sd1, 6'h2A);
    for (int k = 1; k <= 6; k++) send_request(KIND_PUSH, k * 32'sd1111, 6'd0);
    send_request(KIND_POP_AT, 32'sd0, 6'd1);
    send_request(KIND_POP_AT, 32'sd0, 6'd0);
    send_request(KIND_POP_AT, 32'sd0, 6'd2);
    send_request(KIND_POP, 32'sd0, 6'd0);
    send_request(KIND_NOP, 32'sd0, 6'd63);
    send_request(KIND_POP_AT, 32'sd0, 6'd63);
    send_request(KIND_POP_AT, 32'sd0, 6'd1);
    wait_all_results();
  endtask

  // output stalled for long while requests keep coming, store overflows
  task automatic test_backpressure_fill();
    set_group_size(0);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 300;
    for (int k = 0; k < 70; k++) begin
      send_request(KIND_PUSH, $urandom, GROUP_W'($urandom_range(0, 63)));
    end
    send_request(KIND_POP_AT, 32'sd0, 6'd63);
    send_request(KIND_POP_AT, 32'sd0, 6'd0);
    send_request(KIND_PUSH, $urandom, 6'd0);
    send_request(KIND_PUSH, $urandom, 6'd0);
    send_request(KIND_PUSH, $urandom, 6'd0);
    // sender waits for every result before going on
    wait_all_results();
    for (int k = 0; k < 8; k++) send_random_request(30);
    wait_all_results();
  endtask

  // random traffic over many group sizes, extremes included
  task automatic test_group_size_sweep();
    int sizes [12];
    int push_pcts [4];
    sizes = '{127, 64, 1, 2, 5, 3, 63, 0, 0, 0, 0, 0};
    push_pcts = '{35, 55, 75, 92};
    for (int s = 7; s < 12; s++) sizes[s] = $urandom_range(0, 127);
    sizes[7] = 0;
    for (int s = 0; s < 12; s++) begin
      set_group_size(sizes[s]);
      tx_idle = (s % 3) != 1;
      rx_idle = (s % 4) != 2;
      for (int k = 0; k < SEGMENT_REQUESTS; k++) begin
        send_random_request(push_pcts[(s + k / 32) % 4]);
      end
      wait_all_results();
    end
  endtask

  initial begin
    fail_count = 0;
    cycle_count = 0;
    words_held = 0;
    due_wr = 0;
    due_rd = 0;
    group_size_now = GSIZE_RESET;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold_cycles = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= '0;
    in_tdata <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_kinds();
    test_backpressure_fill();
    test_group_size_sweep();

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
